// File: sv/drbdr_pkg.sv
// ----------------------------------------------------------------------------
// drbdr_pkg
// shared widths, codes and controller/datapath interface types for the
// designated router election block
// ----------------------------------------------------------------------------
package drbdr_pkg;

  // neighbor table
  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int SLOT_W    = 4;

  // field widths
  localparam int ADDR_W = 32;
  localparam int ID_W   = 32;
  localparam int PRI_W  = 8;
  localparam int KIND_W = 2;
  localparam int ROLE_W = 2;

  // packed neighbor flags: present, two-way, declares dr, declares bdr, priority
  localparam int FLAG_W      = 4 + PRI_W;
  localparam int FL_PRESENT  = 0;
  localparam int FL_TWOWAY   = 1;
  localparam int FL_DR       = 2;
  localparam int FL_BDR      = 3;
  localparam int FL_PRI_LSB  = 4;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ELECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // own role codes
  localparam logic [ROLE_W-1:0] ROLE_OTHER  = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_BACKUP = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_DR     = 2'd2;

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_OWN_ADDRESS   = 2'd0;
  localparam logic [1:0] REG_OWN_ROUTER_ID = 2'd1;
  localparam logic [1:0] REG_OWN_PRIORITY  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic write_slot;    // store the accepted item into its table slot
    logic clear_dr_bdr;  // forget dr and bdr
    logic capture_prev;  // remember dr and bdr at election start
    logic init_bdr;      // seed the bdr candidate
    logic init_dr;       // seed the dr candidate
    logic scan_start;    // start a table scan
    logic scan_dr;       // scan mode: 1 dr, 0 bdr
    logic dr_fallback;   // empty dr takes the bdr
    logic load_result;   // load the output register
  } drbdr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_busy;     // scan still issuing or processing entries
    logic again;         // own standing changed, second pass wanted
  } drbdr_sts_t;

endpackage

// File: sv/dr_bdr_election.sv
// ----------------------------------------------------------------------------
// dr_bdr_election
// designated router / backup designated router election engine
// ----------------------------------------------------------------------------
// The block keeps a 16-slot neighbor table and the current DR and BDR
// addresses. Three item kinds come in on one valid/ready channel: a write
// item stores one neighbor slot and finishes in the cycle it is accepted;
// a clear item forgets DR and BDR, also in the cycle it is accepted; an
// elect item runs the election and produces exactly one result item. An
// election pass picks the BDR among eligible routers that do not declare
// DR (BDR declarers first, then priority, then router id, later slots
// winning ties), then the DR among DR declarers, with the new BDR standing
// in for an empty DR. When this router's own DR or BDR standing moved, one
// more pass runs. Each pass holds two scans (a seeding step, 16 table
// entries issued one per cycle to the registered-read id/address ram, one
// compare stage behind the read and a step to see the scan finish), plus
// fallback and decision steps. The result is loaded after the last pass;
// the input is ready again in the cycle after the load. The result sits in
// an output register so writes and clears can be taken while it waits; a
// following elect item is accepted and runs, but its result is held in the
// last step, with the input held off, until the previous result has been
// taken. Kind 3 is accepted and ignored. The own address, router id and
// priority live in APB registers at byte addresses 0, 4 and 8; they should
// only be written while no election is in flight.
// ----------------------------------------------------------------------------
module dr_bdr_election
  import drbdr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,

  // item input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic                  entry_present_i,
  input  logic                  two_way_reached_i,
  input  logic [PRI_W-1:0]      neighbor_priority_i,
  input  logic [ID_W-1:0]       neighbor_id_i,
  input  logic [ADDR_W-1:0]     neighbor_address_i,
  input  logic                  declares_dr_i,
  input  logic                  declares_bdr_i,

  // result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ADDR_W-1:0]     dr_address_o,
  output logic [ADDR_W-1:0]     bdr_address_o,
  output logic [ROLE_W-1:0]     own_role_o,
  output logic                  dr_changed_o,
  output logic                  dr_is_neighbor_o,
  output logic [SLOT_W-1:0]     dr_slot_o
);

  // own router settings from the register file
  logic [ADDR_W-1:0] own_address;
  logic [ID_W-1:0]   own_router_id;
  logic [PRI_W-1:0]  own_priority;

  // sequencer <-> datapath
  drbdr_cmd_t cmd;
  drbdr_sts_t sts;

  drbdr_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .own_address_o   (own_address),
    .own_router_id_o (own_router_id),
    .own_priority_o  (own_priority)
  );

  // intake, scan ordering, pass count and result handshake
  drbdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // neighbor table, candidate compare and result register
  drbdr_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .own_address_i       (own_address),
    .own_router_id_i     (own_router_id),
    .own_priority_i      (own_priority),
    .slot_i              (slot_i),
    .entry_present_i     (entry_present_i),
    .two_way_reached_i   (two_way_reached_i),
    .neighbor_priority_i (neighbor_priority_i),
    .neighbor_id_i       (neighbor_id_i),
    .neighbor_address_i  (neighbor_address_i),
    .declares_dr_i       (declares_dr_i),
    .declares_bdr_i      (declares_bdr_i),
    .dr_address_o        (dr_address_o),
    .bdr_address_o       (bdr_address_o),
    .own_role_o          (own_role_o),
    .dr_changed_o        (dr_changed_o),
    .dr_is_neighbor_o    (dr_is_neighbor_o),
    .dr_slot_o           (dr_slot_o)
  );

endmodule

// File: sv/drbdr_ram.sv
// ----------------------------------------------------------------------------
// drbdr_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module drbdr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/drbdr_regs.sv
// ----------------------------------------------------------------------------
// drbdr_regs
// apb configuration registers: own address, own router id, own priority
// ----------------------------------------------------------------------------
module drbdr_regs
  import drbdr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [ADDR_W-1:0]     own_address_o,
  output logic [ID_W-1:0]       own_router_id_o,
  output logic [PRI_W-1:0]      own_priority_o
);

  logic [ADDR_W-1:0] own_address_q;
  logic [ID_W-1:0]   own_router_id_q;
  logic [PRI_W-1:0]  own_priority_q;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q   <= ADDR_W'(1);
      own_router_id_q <= '0;
      own_priority_q  <= PRI_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OWN_ADDRESS:   own_address_q   <= pwdata[ADDR_W-1:0];
        REG_OWN_ROUTER_ID: own_router_id_q <= pwdata[ID_W-1:0];
        REG_OWN_PRIORITY:  own_priority_q  <= pwdata[PRI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OWN_ADDRESS:   prdata = APB_DATA_W'(own_address_q);
      REG_OWN_ROUTER_ID: prdata = APB_DATA_W'(own_router_id_q);
      REG_OWN_PRIORITY:  prdata = APB_DATA_W'(own_priority_q);
      default:           prdata = '0;
    endcase
  end

  assign own_address_o   = own_address_q;
  assign own_router_id_o = own_router_id_q;
  assign own_priority_o  = own_priority_q;

endmodule

// File: sv/drbdr_ctrl.sv
// ----------------------------------------------------------------------------
// drbdr_ctrl
// election sequencer: item intake, scan ordering, pass count, result handoff
// ----------------------------------------------------------------------------
module drbdr_ctrl
  import drbdr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] kind_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output drbdr_cmd_t        cmd_o,
  input  drbdr_sts_t        sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BDR_INIT,
    ST_BDR_SCAN,
    ST_DR_INIT,
    ST_DR_SCAN,
    ST_FALLBACK,
    ST_DECIDE,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   pass_q;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o              = '0;
    cmd_o.write_slot   = accept && (kind_i == KIND_WRITE);
    cmd_o.clear_dr_bdr = accept && (kind_i == KIND_CLEAR);
    cmd_o.capture_prev = accept && (kind_i == KIND_ELECT);
    cmd_o.init_bdr     = (state_q == ST_BDR_INIT);
    cmd_o.init_dr      = (state_q == ST_DR_INIT);
    cmd_o.scan_start   = cmd_o.init_bdr || cmd_o.init_dr;
    cmd_o.scan_dr      = cmd_o.init_dr;
    cmd_o.dr_fallback  = (state_q == ST_FALLBACK);
    cmd_o.load_result  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.capture_prev) begin
            pass_q  <= 1'b0;
            state_q <= ST_BDR_INIT;
          end
        end
        ST_BDR_INIT: state_q <= ST_BDR_SCAN;
        ST_BDR_SCAN: begin
          if (!sts_i.scan_busy) begin
            state_q <= ST_DR_INIT;
          end
        end
        ST_DR_INIT: state_q <= ST_DR_SCAN;
        ST_DR_SCAN: begin
          if (!sts_i.scan_busy) begin
            state_q <= ST_FALLBACK;
          end
        end
        ST_FALLBACK: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (sts_i.again && !pass_q) begin
            pass_q  <= 1'b1;
            state_q <= ST_BDR_INIT;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd_o.load_result) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/drbdr_dp.sv
// ----------------------------------------------------------------------------
// drbdr_dp
// election datapath: neighbor table, candidate registers, scan pipeline,
// pass decision and result register
// ----------------------------------------------------------------------------
module drbdr_dp
  import drbdr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drbdr_cmd_t        cmd_i,
  output drbdr_sts_t        sts_o,
  input  logic [ADDR_W-1:0] own_address_i,
  input  logic [ID_W-1:0]   own_router_id_i,
  input  logic [PRI_W-1:0]  own_priority_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic              entry_present_i,
  input  logic              two_way_reached_i,
  input  logic [PRI_W-1:0]  neighbor_priority_i,
  input  logic [ID_W-1:0]   neighbor_id_i,
  input  logic [ADDR_W-1:0] neighbor_address_i,
  input  logic              declares_dr_i,
  input  logic              declares_bdr_i,
  output logic [ADDR_W-1:0] dr_address_o,
  output logic [ADDR_W-1:0] bdr_address_o,
  output logic [ROLE_W-1:0] own_role_o,
  output logic              dr_changed_o,
  output logic              dr_is_neighbor_o,
  output logic [SLOT_W-1:0] dr_slot_o
);

  // neighbor table: flags in flops (reset clears), id and address in ram
  logic [FLAG_W-1:0]      flags_q [NUM_SLOTS];
  logic                   slot_ok;
  logic [IDX_W-1:0]       wr_idx;
  logic [ID_W+ADDR_W-1:0] ram_rdata;

  // scan pipeline
  logic             scan_act_q;
  logic [IDX_W-1:0] scan_cnt_q;
  logic             scan_dr_q;
  logic             stage_vld_q;
  logic [IDX_W-1:0] stage_idx_q;

  // election state
  logic [ADDR_W-1:0] cur_dr_q, cur_bdr_q;
  logic [ADDR_W-1:0] prev_dr_q, old_bdr_q;
  logic [PRI_W-1:0]  cpri_q;
  logic [ID_W-1:0]   cid_q;
  logic              declared_q;
  logic              bdr_found_q;
  logic [IDX_W-1:0]  bdr_idx_q;
  logic              dr_nb_q;
  logic [IDX_W-1:0]  dr_idx_q;

  // result register
  logic [ADDR_W-1:0] res_dr_q, res_bdr_q;
  logic [ROLE_W-1:0] res_role_q;
  logic              res_changed_q;
  logic              res_nb_q;
  logic [SLOT_W-1:0] res_slot_q;

  // per-entry evaluation
  logic [FLAG_W-1:0] ent_flags;
  logic [PRI_W-1:0]  ent_pri;
  logic [ID_W-1:0]   ent_id;
  logic [ADDR_W-1:0] ent_addr;
  logic              ent_elig;
  logic              ent_ge;
  logic              take_bdr;
  logic              take_dr;

  // pass decision compares
  logic dr_eq_own, bdr_eq_own, prev_dr_eq_own, old_bdr_eq_own;
  logic dr_moved, bdr_moved, own_pri_nz;

  assign slot_ok = (int'(slot_i) < NUM_SLOTS);
  assign wr_idx  = IDX_W'(slot_i);

  drbdr_ram #(
    .WIDTH (ID_W + ADDR_W),
    .DEPTH (NUM_SLOTS)
  ) u_id_addr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_slot && slot_ok),
    .waddr_i (wr_idx),
    .wdata_i ({neighbor_id_i, neighbor_address_i}),
    .raddr_i (scan_cnt_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        flags_q[i] <= '0;
      end
    end else if (cmd_i.write_slot && slot_ok) begin
      flags_q[wr_idx] <= {neighbor_priority_i, declares_bdr_i, declares_dr_i,
                          two_way_reached_i, entry_present_i};
    end
  end

  // entry under evaluation, ram data lines up with the staged index
  assign ent_flags = flags_q[stage_idx_q];
  assign ent_pri   = ent_flags[FL_PRI_LSB +: PRI_W];
  assign ent_id    = ram_rdata[ADDR_W +: ID_W];
  assign ent_addr  = ram_rdata[ADDR_W-1:0];
  assign ent_elig  = ent_flags[FL_PRESENT] && ent_flags[FL_TWOWAY] && (ent_pri != '0);
  assign ent_ge    = {ent_pri, ent_id} >= {cpri_q, cid_q};

  always_comb begin
    take_bdr = 1'b0;
    take_dr  = 1'b0;
    if (stage_vld_q && ent_elig) begin
      if (scan_dr_q) begin
        take_dr = ent_flags[FL_DR] && ent_ge;
      end else if (!ent_flags[FL_DR]) begin
        // a bdr declarer beats any non-declarer; otherwise priority then id
        if (declared_q) begin
          take_bdr = ent_flags[FL_BDR] && ent_ge;
        end else begin
          take_bdr = ent_flags[FL_BDR] || ent_ge;
        end
      end
    end
  end

  assign own_pri_nz      = (own_priority_i != '0);
  assign dr_eq_own       = (cur_dr_q == own_address_i);
  assign bdr_eq_own      = (cur_bdr_q == own_address_i);
  assign prev_dr_eq_own  = (prev_dr_q == own_address_i);
  assign old_bdr_eq_own  = (old_bdr_q == own_address_i);
  assign dr_moved        = (cur_dr_q != prev_dr_q);
  assign bdr_moved       = (cur_bdr_q != old_bdr_q);

  assign sts_o.scan_busy = scan_act_q || stage_vld_q;
  assign sts_o.again     = (dr_moved && (dr_eq_own || prev_dr_eq_own)) ||
                           (bdr_moved && (bdr_eq_own || old_bdr_eq_own));

  // scan address generation and pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q  <= 1'b0;
      scan_cnt_q  <= '0;
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= scan_act_q;
      if (cmd_i.scan_start) begin
        scan_act_q <= 1'b1;
        scan_cnt_q <= '0;
      end else if (scan_act_q) begin
        scan_act_q <= (scan_cnt_q != IDX_W'(NUM_SLOTS - 1));
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stage_idx_q <= scan_cnt_q;
    if (cmd_i.scan_start) begin
      scan_dr_q <= cmd_i.scan_dr;
    end
  end

  // current dr and bdr survive between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_dr_q  <= '0;
      cur_bdr_q <= '0;
    end else if (cmd_i.clear_dr_bdr) begin
      cur_dr_q  <= '0;
      cur_bdr_q <= '0;
    end else if (cmd_i.init_bdr) begin
      cur_bdr_q <= (!dr_eq_own && own_pri_nz) ? own_address_i : '0;
    end else if (cmd_i.init_dr) begin
      if (!(dr_eq_own && own_pri_nz)) begin
        cur_dr_q <= '0;
      end
    end else if (take_bdr) begin
      cur_bdr_q <= ent_addr;
    end else if (take_dr) begin
      cur_dr_q <= ent_addr;
    end else if (cmd_i.dr_fallback && (cur_dr_q == '0)) begin
      cur_dr_q <= cur_bdr_q;
    end
  end

  // candidate and bookkeeping registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_prev) begin
      prev_dr_q <= cur_dr_q;
      old_bdr_q <= cur_bdr_q;
    end

    if (cmd_i.init_bdr) begin
      bdr_found_q <= 1'b0;
      bdr_idx_q   <= '0;
      if (!dr_eq_own && own_pri_nz) begin
        declared_q <= bdr_eq_own;
        cpri_q     <= own_priority_i;
        cid_q      <= own_router_id_i;
      end else begin
        declared_q <= 1'b0;
        cpri_q     <= '0;
        cid_q      <= '0;
      end
    end else if (cmd_i.init_dr) begin
      dr_nb_q  <= 1'b0;
      dr_idx_q <= '0;
      if (dr_eq_own && own_pri_nz) begin
        cpri_q <= own_priority_i;
        cid_q  <= own_router_id_i;
      end else begin
        cpri_q <= '0;
        cid_q  <= '0;
      end
    end else if (take_bdr) begin
      bdr_found_q <= 1'b1;
      bdr_idx_q   <= stage_idx_q;
      declared_q  <= ent_flags[FL_BDR];
      cpri_q      <= ent_pri;
      cid_q       <= ent_id;
    end else if (take_dr) begin
      dr_nb_q  <= 1'b1;
      dr_idx_q <= stage_idx_q;
      cpri_q   <= ent_pri;
      cid_q    <= ent_id;
    end else if (cmd_i.dr_fallback && (cur_dr_q == '0)) begin
      dr_nb_q  <= bdr_found_q;
      dr_idx_q <= bdr_idx_q;
    end

    if (cmd_i.load_result) begin
      res_dr_q      <= cur_dr_q;
      res_bdr_q     <= cur_bdr_q;
      res_changed_q <= dr_moved;
      res_nb_q      <= dr_nb_q;
      res_slot_q    <= dr_nb_q ? SLOT_W'(dr_idx_q) : '0;
      if (dr_eq_own) begin
        res_role_q <= ROLE_DR;
      end else if (bdr_eq_own) begin
        res_role_q <= ROLE_BACKUP;
      end else begin
        res_role_q <= ROLE_OTHER;
      end
    end
  end

  assign dr_address_o     = res_dr_q;
  assign bdr_address_o    = res_bdr_q;
  assign own_role_o       = res_role_q;
  assign dr_changed_o     = res_changed_q;
  assign dr_is_neighbor_o = res_nb_q;
  assign dr_slot_o        = res_slot_q;

endmodule

// File: sim/election_checker.sv
// ----------------------------------------------------------------------------
// election_checker
// watches the dr_bdr_election channels, predicts each election and compares
// ----------------------------------------------------------------------------
// Keeps its own copy of the neighbor table, the current DR and BDR and the
// three own-router registers. It tracks writes on the configuration port and
// items on the input channel. Every accepted elect item queues one predicted
// outcome. Every accepted result is checked field by field against the
// oldest queued outcome.
// ----------------------------------------------------------------------------
module election_checker
  import drbdr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,

  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic                  entry_present_i,
  input  logic                  two_way_reached_i,
  input  logic [PRI_W-1:0]      neighbor_priority_i,
  input  logic [ID_W-1:0]       neighbor_id_i,
  input  logic [ADDR_W-1:0]     neighbor_address_i,
  input  logic                  declares_dr_i,
  input  logic                  declares_bdr_i,

  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [ADDR_W-1:0]     dr_address_i,
  input  logic [ADDR_W-1:0]     bdr_address_i,
  input  logic [ROLE_W-1:0]     own_role_i,
  input  logic                  dr_changed_i,
  input  logic                  dr_is_neighbor_i,
  input  logic [SLOT_W-1:0]     dr_slot_i,

  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic              present;
    logic              two_way;
    logic              decl_dr;
    logic              decl_bdr;
    logic [PRI_W-1:0]  pri;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
  } neighbor_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dr;
    logic [ADDR_W-1:0] bdr;
    logic [ROLE_W-1:0] role;
    logic              changed;
    logic              dr_nb;
    logic [SLOT_W-1:0] dr_slot;
  } outcome_t;

  neighbor_t         nbr_tbl [NUM_SLOTS];
  logic [ADDR_W-1:0] cur_dr;
  logic [ADDR_W-1:0] cur_bdr;
  logic [ADDR_W-1:0] own_addr;
  logic [ID_W-1:0]   own_id;
  logic [PRI_W-1:0]  own_pri;

  outcome_t          election_outcomes [$];
  outcome_t          oldest;
  int                mismatches = 0;

  function automatic logic is_eligible(input neighbor_t n);
    return n.present && n.two_way && (n.pri != '0);
  endfunction

  // one election, up to two passes, updates cur_dr and cur_bdr
  function automatic outcome_t predict_election();
    logic [ADDR_W-1:0] prev_dr;
    logic [ADDR_W-1:0] old_bdr;
    logic [ID_W-1:0]   cid;
    logic [PRI_W-1:0]  cpri;
    logic              declared;
    logic              bdr_found;
    logic              dr_nb;
    logic              again;
    logic              take;
    logic [SLOT_W-1:0] bdr_idx;
    logic [SLOT_W-1:0] dr_idx;
    int                pass;
    int                i;
    outcome_t          res;

    prev_dr  = cur_dr;
    old_bdr  = cur_bdr;
    dr_nb    = 1'b0;
    dr_idx   = '0;
    pass     = 0;
    again    = 1'b1;
    while (again && pass < 2) begin
      // bdr: eligible non-dr-declarers, bdr declarers first
      bdr_found = 1'b0;
      bdr_idx   = '0;
      if (cur_dr != own_addr && own_pri != '0) begin
        declared = (cur_bdr == own_addr);
        cur_bdr  = own_addr;
        cpri     = own_pri;
        cid      = own_id;
      end else begin
        cur_bdr  = '0;
        cpri     = '0;
        cid      = '0;
        declared = 1'b0;
      end
      for (i = 0; i < NUM_SLOTS; i++) begin
        take = is_eligible(nbr_tbl[i]) && !nbr_tbl[i].decl_dr &&
               !(declared && !nbr_tbl[i].decl_bdr);
        if (take && (declared || !nbr_tbl[i].decl_bdr))
          take = !(nbr_tbl[i].pri < cpri ||
                   (nbr_tbl[i].pri == cpri && nbr_tbl[i].id < cid));
        if (take) begin
          bdr_found = 1'b1;
          bdr_idx   = i[SLOT_W-1:0];
          cur_bdr   = nbr_tbl[i].addr;
          declared  = nbr_tbl[i].decl_bdr;
          cpri      = nbr_tbl[i].pri;
          cid       = nbr_tbl[i].id;
        end
      end

      // dr: among dr declarers, empty dr takes the bdr
      dr_nb  = 1'b0;
      dr_idx = '0;
      if (cur_dr == own_addr && own_pri != '0) begin
        cpri = own_pri;
        cid  = own_id;
      end else begin
        cur_dr = '0;
        cpri   = '0;
        cid    = '0;
      end
      for (i = 0; i < NUM_SLOTS; i++) begin
        take = is_eligible(nbr_tbl[i]) && nbr_tbl[i].decl_dr &&
               !(nbr_tbl[i].pri < cpri ||
                 (nbr_tbl[i].pri == cpri && nbr_tbl[i].id < cid));
        if (take) begin
          dr_nb  = 1'b1;
          dr_idx = i[SLOT_W-1:0];
          cur_dr = nbr_tbl[i].addr;
          cpri   = nbr_tbl[i].pri;
          cid    = nbr_tbl[i].id;
        end
      end
      if (cur_dr == '0) begin
        cur_dr = cur_bdr;
        dr_nb  = bdr_found;
        dr_idx = bdr_idx;
      end

      // own standing moved: one more pass
      again = (cur_dr != prev_dr && (cur_dr == own_addr || prev_dr == own_addr)) ||
              (cur_bdr != old_bdr && (cur_bdr == own_addr || old_bdr == own_addr));
      pass++;
    end

    res.dr      = cur_dr;
    res.bdr     = cur_bdr;
    res.role    = (cur_dr == own_addr)  ? ROLE_DR :
                  (cur_bdr == own_addr) ? ROLE_BACKUP : ROLE_OTHER;
    res.changed = (cur_dr != prev_dr);
    res.dr_nb   = dr_nb;
    res.dr_slot = dr_nb ? dr_idx : '0;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) nbr_tbl[i] = '0;
      cur_dr   = '0;
      cur_bdr  = '0;
      own_addr = 32'd1;
      own_id   = '0;
      own_pri  = 8'd1;
      election_outcomes.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // results first, so a result can never match an election taken this edge
      if (out_valid_i && out_ready_i) begin
        if (election_outcomes.size() == 0) begin
          mismatches++;
          $error("result item with no election outstanding");
        end else begin
          oldest = election_outcomes.pop_front();
          check_field("dr_address", oldest.dr, dr_address_i);
          check_field("bdr_address", oldest.bdr, bdr_address_i);
          check_field("own_role", oldest.role, own_role_i);
          check_field("dr_changed", oldest.changed, dr_changed_i);
          check_field("dr_is_neighbor", oldest.dr_nb, dr_is_neighbor_i);
          check_field("dr_slot", oldest.dr_slot, dr_slot_i);
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_OWN_ADDRESS:   own_addr = pwdata;
          REG_OWN_ROUTER_ID: own_id   = pwdata;
          REG_OWN_PRIORITY:  own_pri  = pwdata[PRI_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          KIND_WRITE: nbr_tbl[slot_i] = {entry_present_i, two_way_reached_i,
                                         declares_dr_i, declares_bdr_i,
                                         neighbor_priority_i, neighbor_id_i,
                                         neighbor_address_i};
          KIND_ELECT: election_outcomes.push_back(predict_election());
          KIND_CLEAR: begin
            cur_dr  = '0;
            cur_bdr = '0;
          end
          default: ;
        endcase
      end

      fail_count_o <= mismatches;
      pending_o    <= election_outcomes.size();
    end
  end

endmodule

// File: sim/dr_bdr_election_test.sv
// ----------------------------------------------------------------------------
// dr_bdr_election_test
// stimulus and verdict for the designated router election engine
// ----------------------------------------------------------------------------
// Drives the item channel and the configuration port, paces the result
// channel, and leaves all prediction and comparison to election_checker.
// A short directed run covers the field extremes, every item kind, ties,
// ineligible neighbors and a zero neighbor address. Six random phases follow,
// each with its own own-router settings (extremes and own address zero among
// them), with bursty idling on both sides, one long result hold-off that
// backs up the input, and a final phase with no idling at all.
// ----------------------------------------------------------------------------
module dr_bdr_election_test;
  import drbdr_pkg::*;

  // kind 3 has no meaning, the block must swallow it
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES    = 100;     // settling wait after the last result
  localparam int LONG_HOLD       = 300;     // result side hold-off
  localparam int CYCLE_LIMIT     = 500000;

  logic                  clk_i;
  logic                  rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [KIND_W-1:0]     kind_i;
  logic [SLOT_W-1:0]     slot_i;
  logic                  entry_present_i;
  logic                  two_way_reached_i;
  logic [PRI_W-1:0]      neighbor_priority_i;
  logic [ID_W-1:0]       neighbor_id_i;
  logic [ADDR_W-1:0]     neighbor_address_i;
  logic                  declares_dr_i;
  logic                  declares_bdr_i;

  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [ADDR_W-1:0]     dr_address_o;
  logic [ADDR_W-1:0]     bdr_address_o;
  logic [ROLE_W-1:0]     own_role_o;
  logic                  dr_changed_o;
  logic                  dr_is_neighbor_o;
  logic [SLOT_W-1:0]     dr_slot_o;

  int                    mismatch_total;
  int                    results_due;

  // pacing shared by the sender and the result side
  int                    idle_pct = 25;
  logic                  hold_req = 1'b0;
  logic [ADDR_W-1:0]     cfg_addr = 32'd1;   // mirrors own_address for collisions
  int                    cycles = 0;

  dr_bdr_election DUT (.*);

  election_checker chk (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .kind_i              (kind_i),
    .slot_i              (slot_i),
    .entry_present_i     (entry_present_i),
    .two_way_reached_i   (two_way_reached_i),
    .neighbor_priority_i (neighbor_priority_i),
    .neighbor_id_i       (neighbor_id_i),
    .neighbor_address_i  (neighbor_address_i),
    .declares_dr_i       (declares_dr_i),
    .declares_bdr_i      (declares_bdr_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .dr_address_i        (dr_address_o),
    .bdr_address_i       (bdr_address_o),
    .own_role_i          (own_role_o),
    .dr_changed_i        (dr_changed_o),
    .dr_is_neighbor_i    (dr_is_neighbor_o),
    .dr_slot_i           (dr_slot_o),
    .fail_count_o        (mismatch_total),
    .pending_o           (results_due)
  );

  // 12 unit clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("dr_bdr_election regression: fail");
      $finish;
    end
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    logic hold_done;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        // keep results parked so the next elect item backs up the input
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // offer one item and hold it until accepted, then maybe leave a gap
  task automatic put_item(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
                          input logic present, input logic two_way,
                          input logic [PRI_W-1:0] pri, input logic [ID_W-1:0] id,
                          input logic [ADDR_W-1:0] addr,
                          input logic ddr, input logic dbdr);
    in_valid_i          <= 1'b1;
    kind_i              <= k;
    slot_i              <= s;
    entry_present_i     <= present;
    two_way_reached_i   <= two_way;
    neighbor_priority_i <= pri;
    neighbor_id_i       <= id;
    neighbor_address_i  <= addr;
    declares_dr_i       <= ddr;
    declares_bdr_i      <= dbdr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // sender idle burst of random length
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic write_slot(input logic [SLOT_W-1:0] s, input logic present,
                            input logic two_way, input logic [PRI_W-1:0] pri,
                            input logic [ID_W-1:0] id, input logic [ADDR_W-1:0] addr,
                            input logic ddr, input logic dbdr);
    put_item(KIND_WRITE, s, present, two_way, pri, id, addr, ddr, dbdr);
  endtask

  // elect, clear or unused kind: neighbor fields are noise
  task automatic command(input logic [KIND_W-1:0] k);
    put_item(k, SLOT_W'($urandom), 1'($urandom), 1'($urandom), PRI_W'($urandom),
             $urandom, $urandom, 1'($urandom), 1'($urandom));
  endtask

  // apb write: setup phase then access phase
  task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop offering, wait for every outstanding result, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [ADDR_W-1:0] addr, input logic [ID_W-1:0] id,
                           input logic [PRI_W-1:0] pri);
    write_reg(REG_OWN_ADDRESS, addr);
    write_reg(REG_OWN_ROUTER_ID, id);
    write_reg(REG_OWN_PRIORITY, {24'd0, pri});
    cfg_addr = addr;
  endtask

  // mostly table writes followed by elections, some clears and unused kinds
  task automatic random_traffic(input int count);
    int                roll;
    logic [PRI_W-1:0]  pri;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // small priority and id pools make ties common
        case ($urandom_range(0, 5))
          0:       pri = '0;
          1:       pri = '1;
          2:       pri = PRI_W'($urandom);
          default: pri = PRI_W'($urandom_range(1, 3));
        endcase
        case ($urandom_range(0, 5))
          0:       id = '0;
          1:       id = '1;
          2, 3:    id = $urandom_range(0, 3);
          default: id = $urandom;
        endcase
        // addresses sometimes zero or equal to our own
        case ($urandom_range(0, 7))
          0:       addr = '0;
          1:       addr = cfg_addr;
          2:       addr = '1;
          3, 4:    addr = $urandom_range(1, 6);
          default: addr = $urandom;
        endcase
        write_slot(SLOT_W'($urandom_range(0, 15)), $urandom_range(0, 99) < 85,
                   $urandom_range(0, 99) < 85, pri, id, addr,
                   $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 30);
      end else if (roll < 85) begin
        command(KIND_ELECT);
      end else if (roll < 94) begin
        command(KIND_CLEAR);
      end else begin
        command(KIND_UNUSED);
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_valid_i          = 1'b0;
    kind_i              = KIND_WRITE;
    slot_i              = '0;
    entry_present_i     = 1'b0;
    two_way_reached_i   = 1'b0;
    neighbor_priority_i = '0;
    neighbor_id_i       = '0;
    neighbor_address_i  = '0;
    declares_dr_i       = 1'b0;
    declares_bdr_i      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset settings: own address 1, id 0, priority 1
    command(KIND_ELECT);                                              // empty table
    write_slot(4'd0, 1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // dr declarer with address zero loses to the bdr
    write_slot(4'd15, 1'b1, 1'b1, 8'd1, 32'd0, 32'd0, 1'b1, 1'b0);
    command(KIND_ELECT);
    // not present, not two-way, priority zero: all skipped
    write_slot(4'd7, 1'b0, 1'b1, 8'd200, 32'd9, 32'h0A00_0007, 1'b1, 1'b0);
    write_slot(4'd8, 1'b1, 1'b0, 8'd200, 32'd9, 32'h0A00_0008, 1'b1, 1'b0);
    write_slot(4'd9, 1'b1, 1'b1, 8'd0, 32'd9, 32'h0A00_0009, 1'b1, 1'b1);
    command(KIND_ELECT);
    // equal priority and id: the later slot wins, for dr and for bdr
    write_slot(4'd3, 1'b1, 1'b1, 8'd100, 32'd5, 32'h0A00_0003, 1'b1, 1'b0);
    write_slot(4'd4, 1'b1, 1'b1, 8'd100, 32'd5, 32'h0A00_0004, 1'b1, 1'b0);
    write_slot(4'd5, 1'b1, 1'b1, 8'd50, 32'd7, 32'h0A00_0005, 1'b0, 1'b1);
    write_slot(4'd6, 1'b1, 1'b1, 8'd50, 32'd7, 32'h0A00_0006, 1'b0, 1'b1);
    command(KIND_ELECT);
    command(KIND_CLEAR);
    command(KIND_ELECT);
    command(KIND_UNUSED);
    write_slot(4'd4, 1'b0, 1'b0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    write_slot(4'd3, 1'b0, 1'b0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    command(KIND_ELECT);
    // declares both dr and bdr
    write_slot(4'd0, 1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    command(KIND_ELECT);
    // a neighbor that carries our own address
    write_slot(4'd1, 1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 1'b0);
    command(KIND_ELECT);
    command(KIND_CLEAR);
    command(KIND_ELECT);

    // random phases, each under its own settings
    for (int phase = 1; phase <= 6; phase++) begin
      wait_idle();
      case (phase)
        1: configure(32'h0A00_0001, 32'h0A00_0001, 8'd1);
        2: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        3: configure(32'd1, 32'd0, 8'd0);                 // ineligible self
        4: configure(32'd0, $urandom, PRI_W'($urandom_range(1, 255)));  // own address zero
        5: configure($urandom_range(1, 8), $urandom_range(0, 3),
                     PRI_W'($urandom_range(1, 3)));
        default: configure($urandom, $urandom, PRI_W'($urandom));
      endcase
      // phase 2 and the last phase run without idling
      idle_pct <= (phase == 2 || phase == 6) ? 0 : 25;
      if (phase == 3) hold_req <= 1'b1;
      random_traffic(ITEMS_PER_PHASE);
    end

    wait_idle();
    if (mismatch_total == 0) begin
      $display("dr_bdr_election regression: pass");
    end else begin
      $display("dr_bdr_election regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
sv/drbdr_pkg.sv
sv/drbdr_ram.sv
sv/drbdr_regs.sv
sv/drbdr_ctrl.sv
sv/drbdr_dp.sv
sv/dr_bdr_election.sv
sim/election_checker.sv
sim/dr_bdr_election_test.sv
